/* sv/fvtc_pkg.sv */
// Package for the FAT volume type classifier.
// Holds the item types, the class codes and the fixed limits.
// No dependencies.
package fvtc_pkg;

  localparam int unsigned SectorBytesDefault = 512;
  localparam int unsigned DividendW = 32;
  localparam int unsigned SpcW = 8;
  localparam int unsigned MetaW = 25;
  localparam int unsigned RootW = 13;
  localparam int unsigned RootNumW = 22;
  localparam logic [DividendW-1:0] Fat12Limit = 32'd4085;
  localparam logic [DividendW-1:0] Fat16Limit = 32'd65525;
  localparam logic [5:0] DirEntryBytes = 6'd32;

  typedef enum logic [1:0] {
    CLASS_NONE  = 2'd0,
    CLASS_FAT12 = 2'd1,
    CLASS_FAT16 = 2'd2
  } vol_class_e;

  typedef struct packed {
    logic [15:0] sector_bytes_field;
    logic [7:0]  cluster_sectors;
    logic [15:0] reserved_count;
    logic [7:0]  fat_copies;
    logic [15:0] root_entry_count;
    logic [15:0] total_small;
    logic [15:0] fat_size;
    logic [31:0] total_large;
  } in_item_t;

  typedef struct packed {
    logic                 bad;
    logic [SpcW-1:0]      spc;
    logic [SpcW-1:0]      rem;
    logic [DividendW-1:0] dvd;
    logic [DividendW-1:0] quo;
  } cell_t;

endpackage

/* sv/fvtc_if.sv */
// Channel interfaces of the FAT volume type classifier.
// Carries valid, ready and the payload fields; no dependencies.
interface fvtc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sector_bytes_field;
  logic [7:0]  cluster_sectors;
  logic [15:0] reserved_count;
  logic [7:0]  fat_copies;
  logic [15:0] root_entry_count;
  logic [15:0] total_small;
  logic [15:0] fat_size;
  logic [31:0] total_large;

  modport source (
    output valid, sector_bytes_field, cluster_sectors, reserved_count, fat_copies,
           root_entry_count, total_small, fat_size, total_large,
    input  ready
  );
  modport sink (
    input  valid, sector_bytes_field, cluster_sectors, reserved_count, fat_copies,
           root_entry_count, total_small, fat_size, total_large,
    output ready
  );
endinterface

interface fvtc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] volume_class;

  modport source (output valid, volume_class, input ready);
  modport sink (input valid, volume_class, output ready);
endinterface

/* sv/fvtc_front.sv */
// Front stages: field checks, root directory size, metadata area and data sectors.
// Depends on fvtc_pkg; feeds the first divider cell.
module fvtc_front import fvtc_pkg::*; #(
  parameter int unsigned SECTOR_BYTES = SectorBytesDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  in_item_t item_i,
  output logic     valid_o,
  output cell_t    cell_o
);

  localparam int unsigned RootShift = RootNumW + $clog2(SECTOR_BYTES);
  localparam logic [63:0] RootMul64 =
      ((64'd1 << RootShift) + 64'(SECTOR_BYTES) - 64'd1) / 64'(SECTOR_BYTES);
  localparam logic [RootNumW:0] RootMul = RootMul64[RootNumW:0];
  localparam logic [RootNumW-1:0] RootBias = RootNumW'(SECTOR_BYTES - 1);
  localparam int unsigned ProdW = 2 * RootNumW + 1;

  logic                 v1_q, v2_q, v3_q;
  logic                 bad1_d, bad1_q, bad2_q;
  logic [DividendW-1:0] tot1_d, tot1_q, tot2_q;
  logic [15:0]          rsv1_q;
  logic [23:0]          fprod1_q;
  logic [ProdW-1:0]     rprod1_q;
  logic [SpcW-1:0]      spc1_q, spc2_q;
  logic [RootNumW-1:0]  root_num;
  logic [RootW-1:0]     root_secs;
  logic [MetaW-1:0]     meta2_d, meta2_q;
  cell_t                cell3_d, cell3_q;

  always_comb begin
    tot1_d = (item_i.total_small != 16'd0) ? {16'd0, item_i.total_small} : item_i.total_large;
    bad1_d = (item_i.sector_bytes_field != 16'(SECTOR_BYTES)) ||
             (item_i.cluster_sectors == 8'd0) || (item_i.reserved_count == 16'd0) ||
             (item_i.fat_copies == 8'd0) || (item_i.fat_size == 16'd0) ||
             (item_i.root_entry_count == 16'd0) || (tot1_d == '0);
    root_num = RootNumW'({item_i.root_entry_count, 5'd0}) + RootBias;
  end

  always_comb begin
    root_secs = RootW'(rprod1_q >> RootShift);
    meta2_d = MetaW'(rsv1_q) + MetaW'(fprod1_q) + MetaW'(root_secs);
  end

  always_comb begin
    cell3_d.bad = bad2_q || ({7'd0, meta2_q} >= tot2_q);
    cell3_d.spc = spc2_q;
    cell3_d.rem = '0;
    cell3_d.dvd = tot2_q - DividendW'(meta2_q);
    cell3_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bad1_q   <= bad1_d;
      tot1_q   <= tot1_d;
      rsv1_q   <= item_i.reserved_count;
      fprod1_q <= {16'd0, item_i.fat_copies} * {8'd0, item_i.fat_size};
      rprod1_q <= {{(RootNumW+1){1'b0}}, root_num} * {{RootNumW{1'b0}}, RootMul};
      spc1_q   <= item_i.cluster_sectors;
      bad2_q   <= bad1_q;
      tot2_q   <= tot1_q;
      meta2_q  <= meta2_d;
      spc2_q   <= spc1_q;
      cell3_q  <= cell3_d;
    end
  end

  assign valid_o = v3_q;
  assign cell_o  = cell3_q;

endmodule

/* sv/fvtc_div_cell.sv */
// One cell of the restoring divider row: produces one quotient bit per item.
// Depends on fvtc_pkg.
module fvtc_div_cell import fvtc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  cell_t cell_i,
  output logic  valid_o,
  output cell_t cell_o
);

  logic          valid_q;
  cell_t         cell_d, cell_q;
  logic [SpcW:0] trial;
  logic          fits;

  always_comb begin
    trial = {cell_i.rem, cell_i.dvd[DividendW-1]};
    fits = trial >= {1'b0, cell_i.spc};
    cell_d.bad = cell_i.bad;
    cell_d.spc = cell_i.spc;
    cell_d.rem = fits ? SpcW'(trial - {1'b0, cell_i.spc}) : trial[SpcW-1:0];
    cell_d.dvd = {cell_i.dvd[DividendW-2:0], 1'b0};
    cell_d.quo = {cell_i.quo[DividendW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

/* sv/fat_volume_type_classifier.sv */
// FAT volume type classifier, top level: front stages, divider row and output register.
// One transaction per cycle is accepted while the output register is free or taken.
// The whole pipeline advances together whenever the output register is free or taken.
// Reset clears all valid flags asynchronously; no item is in flight afterwards.
// Depends on fvtc_pkg, fvtc_if, fvtc_front and fvtc_div_cell.
module fat_volume_type_classifier import fvtc_pkg::*; #(
  parameter int unsigned SECTOR_BYTES = SectorBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fvtc_in_if.sink           in_i,
  fvtc_out_if.source        out_o
);

  logic       en;
  in_item_t   item;
  logic       chain_valid [DividendW+1];
  cell_t      chain_cell  [DividendW+1];
  cell_t      last;
  logic       out_valid_q;
  logic [1:0] class_d, class_q;

  assign en = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    item.sector_bytes_field = in_i.sector_bytes_field;
    item.cluster_sectors    = in_i.cluster_sectors;
    item.reserved_count     = in_i.reserved_count;
    item.fat_copies         = in_i.fat_copies;
    item.root_entry_count   = in_i.root_entry_count;
    item.total_small        = in_i.total_small;
    item.fat_size           = in_i.fat_size;
    item.total_large        = in_i.total_large;
  end

  fvtc_front #(.SECTOR_BYTES(SECTOR_BYTES)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .item_i  (item),
    .valid_o (chain_valid[0]),
    .cell_o  (chain_cell[0])
  );

  for (genvar k = 0; k < DividendW; k++) begin : g_cell
    fvtc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[k]),
      .cell_i  (chain_cell[k]),
      .valid_o (chain_valid[k+1]),
      .cell_o  (chain_cell[k+1])
    );
  end

  assign last = chain_cell[DividendW];

  always_comb begin
    if (last.bad) begin
      class_d = CLASS_NONE;
    end else if (last.quo < Fat12Limit) begin
      class_d = CLASS_FAT12;
    end else if (last.quo < Fat16Limit) begin
      class_d = CLASS_FAT16;
    end else begin
      class_d = CLASS_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain_valid[DividendW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      class_q <= class_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.volume_class = class_q;

endmodule

/* sv/fvtc_checker.sv */
// Port checker for the FAT volume type classifier, bound to the top level.
// Depends on fvtc_pkg and the top level's channel ports.
module fvtc_checker import fvtc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] volume_class_i
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("Result shown during reset.");

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("Input ready does not follow the output register state.");

  a_class_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (volume_class_i == CLASS_NONE || volume_class_i == CLASS_FAT12 ||
                     volume_class_i == CLASS_FAT16))
    else $error("Volume class code out of range.");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(volume_class_i))
    else $error("Stalled result changed.");

endmodule

bind fat_volume_type_classifier fvtc_checker u_fvtc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .volume_class_i (out_o.volume_class)
);
